// ----- rtl/d96_pkg.sv -----
// shared types and constants for the 96-bit decimal arithmetic unit
`timescale 1ns / 1ps
package d96_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_BAD = 2'd3
  } func_e;

  localparam int unsigned MantW    = 96;
  localparam int unsigned ProdW    = 2 * MantW;
  localparam int unsigned ChunkW   = 16;
  localparam int unsigned DivSteps = ProdW / ChunkW;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam logic [5:0]  MaxScale = 6'd28;
  // floor(x / 10) = (x * Recip10) >> 24 for any x below 2^22
  localparam logic [20:0] Recip10  = 21'd1677722;
  localparam int unsigned RecipSh  = 24;

  typedef struct packed {
    logic       done;
    logic [3:0] rem;
  } div_sts_t;

endpackage

// ----- rtl/decimal96_add_sub_mul_unit.sv -----
// top level: sequencer, shared 32x32 multiplier and result register
`timescale 1ns / 1ps
// Unsigned 96-bit decimal add, subtract and multiply with power-of-ten scales.
// One item is worked on at a time; in_stall_o is high from acceptance until
// the result has been taken. Subtract, plain add and an unused function code
// go straight to the result register. An add that carries past 96 bits goes
// once through the divide-by-ten unit if its scale is nonzero, else it is
// flagged as an error. Multiply runs nine partial products through one 32x32
// multiplier, then strips trailing zeros one digit at a time through the
// divide-by-ten unit, which handles 16 bits a cycle; at most one digit is
// tried per unit of the summed scale.
module decimal96_add_sub_mul_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] a_low_i,
  input  logic [31:0] a_high_i,
  input  logic [4:0]  a_scale_i,
  input  logic [63:0] b_low_i,
  input  logic [31:0] b_high_i,
  input  logic [4:0]  b_scale_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] r_low_o,
  output logic [31:0] r_high_o,
  output logic [4:0]  r_scale_o,
  output logic        error_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_NORM = 5'b00100,
    S_DIVW = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                     st_q, st_d;
  d96_pkg::func_e             func_q;
  logic [95:0]                a_q, b_q;
  logic [5:0]                 scale_q;
  logic [d96_pkg::ProdW-1:0]  acc_q;
  logic [63:0]                prod_q;
  logic [2:0]                 pos_q;
  logic [1:0]                 i_q, j_q;
  logic                       mul_go_q, pvld_q;
  logic [95:0]                res_q;
  logic [4:0]                 rscale_q;
  logic                       err_q;

  logic                       in_acc;
  logic [96:0]                sum97;
  logic [95:0]                diff;
  logic                       div_start;
  logic [d96_pkg::ProdW-1:0]  quot;
  d96_pkg::div_sts_t          div_sts;
  logic [95:0]                qlow;
  logic                       round_up;
  logic [96:0]                rounded;
  logic [d96_pkg::ProdW-1:0]  prod_sh;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != S_IDLE);
  assign sum97      = {1'b0, a_high_i, a_low_i} + {1'b0, b_high_i, b_low_i};
  assign diff       = {a_high_i, a_low_i} - {b_high_i, b_low_i};
  assign div_start  = (st_q == S_NORM) && !((func_q == d96_pkg::FUNC_MUL) && (scale_q == 6'd0));
  assign qlow       = quot[95:0];
  assign round_up   = (div_sts.rem > 4'd5) || ((div_sts.rem == 4'd5) && qlow[0]);
  assign rounded    = {1'b0, qlow} + {96'd0, round_up};
  assign prod_sh    = {128'd0, prod_q} << {pos_q, 5'd0};

  d96_div10 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .value_i (acc_q),
    .quot_o  (quot),
    .sts_o   (div_sts)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          if ((func_i == d96_pkg::FUNC_MUL) || ((func_i == d96_pkg::FUNC_ADD) && sum97[96]
              && (a_scale_i != 5'd0))) begin
            st_d = (func_i == d96_pkg::FUNC_MUL) ? S_MUL : S_NORM;
          end else begin
            st_d = S_DONE;
          end
        end
      end
      S_MUL:  if (!mul_go_q && !pvld_q) st_d = S_NORM;
      S_NORM: st_d = div_start ? S_DIVW : S_DONE;
      S_DIVW: begin
        if (div_sts.done) begin
          st_d = ((func_q == d96_pkg::FUNC_MUL) && (div_sts.rem == 4'd0)) ? S_NORM : S_DONE;
        end
      end
      S_DONE: if (!out_stall_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      mul_go_q <= 1'b0;
      pvld_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_IDLE) begin
        mul_go_q <= in_acc && (func_i == d96_pkg::FUNC_MUL);
        pvld_q   <= 1'b0;
      end else if (st_q == S_MUL) begin
        pvld_q <= mul_go_q;
        if (mul_go_q && (i_q == 2'd2) && (j_q == 2'd2)) mul_go_q <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          func_q  <= d96_pkg::func_e'(func_i);
          a_q     <= {a_high_i, a_low_i};
          b_q     <= {b_high_i, b_low_i};
          i_q     <= 2'd0;
          j_q     <= 2'd0;
          scale_q <= {1'b0, a_scale_i};
          acc_q   <= {95'd0, sum97};
          res_q   <= 96'd0;
          rscale_q <= a_scale_i;
          err_q   <= 1'b0;
          case (func_i)
            d96_pkg::FUNC_ADD: begin
              res_q <= sum97[95:0];
              err_q <= sum97[96];
            end
            d96_pkg::FUNC_SUB: res_q <= diff;
            d96_pkg::FUNC_MUL: begin
              scale_q <= {1'b0, a_scale_i} + {1'b0, b_scale_i};
              acc_q   <= '0;
            end
            default: begin
              rscale_q <= 5'd0;
              err_q    <= 1'b1;
            end
          endcase
        end
      end
      S_MUL: begin
        if (mul_go_q) begin
          prod_q <= {32'd0, a_q[{i_q, 5'd0} +: 32]} * {32'd0, b_q[{j_q, 5'd0} +: 32]};
          pos_q  <= {1'b0, i_q} + {1'b0, j_q};
          if (j_q == 2'd2) begin
            j_q <= 2'd0;
            i_q <= i_q + 2'd1;
          end else begin
            j_q <= j_q + 2'd1;
          end
        end
        if (pvld_q) acc_q <= acc_q + prod_sh;
      end
      S_NORM: begin
        if (!div_start) begin
          if ((acc_q[d96_pkg::ProdW-1:96] != '0) || (scale_q > d96_pkg::MaxScale)) begin
            res_q    <= 96'd0;
            rscale_q <= 5'd0;
            err_q    <= 1'b1;
          end else begin
            res_q    <= acc_q[95:0];
            rscale_q <= scale_q[4:0];
            err_q    <= 1'b0;
          end
        end
      end
      S_DIVW: begin
        if (div_sts.done) begin
          if (func_q == d96_pkg::FUNC_MUL) begin
            if (div_sts.rem == 4'd0) begin
              acc_q   <= quot;
              scale_q <= scale_q - 6'd1;
            end else if ((acc_q[d96_pkg::ProdW-1:96] != '0) || (scale_q > d96_pkg::MaxScale)) begin
              res_q    <= 96'd0;
              rscale_q <= 5'd0;
              err_q    <= 1'b1;
            end else begin
              res_q    <= acc_q[95:0];
              rscale_q <= scale_q[4:0];
              err_q    <= 1'b0;
            end
          end else begin
            // add overflow: one digit dropped, round half to even
            res_q    <= rounded[95:0];
            rscale_q <= 5'(scale_q - 6'd1);
            err_q    <= rounded[96];
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = (st_q == S_DONE);
  assign r_low_o     = res_q[63:0];
  assign r_high_o    = res_q[95:64];
  assign r_scale_o   = rscale_q;
  assign error_o     = err_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (st_q != S_IDLE))
    else $error("accepted item left the sequencer idle");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (st_q == S_DIVW))
    else $error("divider finished with nobody waiting");

  a_err_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o && (func_q != d96_pkg::FUNC_ADD))
      |-> ((res_q == 96'd0) && (rscale_q == 5'd0)))
    else $error("multiply or bad code error with nonzero result");

endmodule

// ----- rtl/d96_div10.sv -----
// iterative divide-by-ten unit, sixteen bits of quotient per cycle
`timescale 1ns / 1ps
module d96_div10 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [d96_pkg::ProdW-1:0]     value_i,
  output logic [d96_pkg::ProdW-1:0]     quot_o,
  output d96_pkg::div_sts_t             sts_o
);

  logic [d96_pkg::ProdW-1:0]  work_q, work_d;
  logic [3:0]                 rem_q, rem_d;
  logic [d96_pkg::CntW-1:0]   cnt_q;
  logic                       busy_q, done_q;
  logic [d96_pkg::ChunkW+3:0] cur;
  logic [40:0]                recip_prod;
  logic [d96_pkg::ChunkW-1:0] qchunk;
  logic [d96_pkg::ChunkW+3:0] qtimes10;

  always_comb begin
    cur        = {rem_q, work_q[d96_pkg::ProdW-1 -: d96_pkg::ChunkW]};
    recip_prod = {21'd0, cur} * {20'd0, d96_pkg::Recip10};
    qchunk     = recip_prod[d96_pkg::RecipSh +: d96_pkg::ChunkW];
    qtimes10   = {4'd0, qchunk} * 20'd10;
    rem_d      = 4'(cur - qtimes10);
    work_d     = {work_q[d96_pkg::ProdW-d96_pkg::ChunkW-1:0], qchunk};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == d96_pkg::CntW'(d96_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= value_i;
      rem_q  <= 4'd0;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign quot_o   = work_q;
  assign sts_o.done = done_q;
  assign sts_o.rem  = rem_q;

endmodule
